FILE: rtl/cfc_pkg.sv
// package for the centered fir correlator
// holds sizes, command codes and the controller/datapath interface structs
// no dependencies
package cfc_pkg;

    localparam int MAX_TAPS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 32;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int IDX_BITS    = $clog2(MAX_TAPS);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int CFG_BITS    = 5;
    localparam int TIDX_BITS   = 4;

    // command field codes
    localparam logic CMD_TAP    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic                tap_wr;
        logic                smp_push;
        logic                win_clr;
        logic                acc_clr;
        logic                mac_en;
        logic                out_load;
        logic                out_last;
        logic [IDX_BITS-1:0] lag;
        logic [IDX_BITS-1:0] tap_j;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_BITS-1:0] taps;
        logic [IDX_BITS-1:0] look;
        logic [CNT_BITS-1:0] seen_next;
    } t_dp_sts;

endpackage

FILE: rtl/centered_fir_correlator.sv
// top level of the centered fir correlator
// joins cfc_ctrl and cfc_dp; depends on cfc_pkg
//
// usage
// - input channel (i_valid / o_stall): command 0 loads tap i_item_value at
//   i_tap_index, command 1 delivers one sample; i_last_sample ends a signal
// - output channel (o_valid / i_stall): one filtered value per transaction,
//   o_last_output on the final value of a signal
// - i_cfg_we / i_cfg_data write tap_count; write it only while idle
// - a tap load or a sample that gives no result leaves o_stall low
// - a sample that gives a result runs one multiply-accumulate per tap in use;
//   o_stall is high while they run, and the final tap loads the sum into the
//   result register and raises o_valid
// - the result register parts the two sides: the input opens again while a
//   result waits, and only a finished sum with a result still waiting holds
//   the block (o_stall high) until the receiver takes it
// - a last sample gives up to taps - taps/2 results, one after another,
//   and the window clears with the final one
// - a stalled receiver holds the result unchanged
// - reset clears the taps, the sample window and the count, and sets
//   tap_count to one
module centered_fir_correlator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cfc_pkg::CFG_BITS-1:0]           i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_command,
    input  logic [cfc_pkg::TIDX_BITS-1:0]          i_tap_index,
    input  logic signed [cfc_pkg::SAMPLE_BITS-1:0] i_item_value,
    input  logic                                   i_last_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cfc_pkg::ACC_BITS-1:0]    o_filtered_value,
    output logic                                   o_last_output
);
    import cfc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    cfc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // storage and arithmetic
    cfc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_tap_index      (i_tap_index),
        .i_item_value     (i_item_value),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_filtered_value (o_filtered_value),
        .o_last_output    (o_last_output)
    );

endmodule

FILE: rtl/cfc_dp.sv
// datapath of the centered fir correlator: tap store, sample window,
// tap count register, one multiply-accumulate unit and the result register
// depends on cfc_pkg
module cfc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cfc_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic [cfc_pkg::TIDX_BITS-1:0]        i_tap_index,
    input  logic signed [cfc_pkg::SAMPLE_BITS-1:0] i_item_value,
    input  cfc_pkg::t_dp_cmd                     i_cmd,
    output cfc_pkg::t_dp_sts                     o_sts,
    output logic signed [cfc_pkg::ACC_BITS-1:0]  o_filtered_value,
    output logic                                 o_last_output
);
    import cfc_pkg::*;

    logic [CFG_BITS-1:0]          r_tap_count;
    logic signed [SAMPLE_BITS-1:0] r_kern [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_win  [MAX_TAPS];
    logic [CNT_BITS-1:0]          r_seen;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic signed [ACC_BITS-1:0]   r_out;
    logic                         r_out_last;

    logic [CNT_BITS-1:0]          taps;
    logic [IDX_BITS-1:0]          off;
    logic [IDX_BITS-1:0]          sum_lim;
    logic [IDX_BITS-1:0]          d;
    logic                         use_tap;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [ACC_BITS-1:0]   term;
    logic signed [ACC_BITS-1:0]   n_acc;

    // taps in use: zero acts as one, above the store acts as full
    always_comb begin
        if (r_tap_count == '0) begin
            taps = CNT_BITS'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            taps = CNT_BITS'(MAX_TAPS);
        end else begin
            taps = CNT_BITS'(r_tap_count);
        end
    end

    assign off = IDX_BITS'(taps >> 1);

    // status toward the controller
    always_comb begin
        o_sts.taps = taps;
        o_sts.look = IDX_BITS'(taps - CNT_BITS'(1) - CNT_BITS'(off));
        if (32'(r_seen) >= MAX_TAPS) begin
            o_sts.seen_next = r_seen;
        end else begin
            o_sts.seen_next = r_seen + CNT_BITS'(1);
        end
    end

    // one tap product, zero where the sample lies beyond the newest one
    assign sum_lim = i_cmd.lag + off;
    assign use_tap = (i_cmd.tap_j <= sum_lim);
    assign d       = sum_lim - i_cmd.tap_j;
    assign prod    = PROD_BITS'(r_win[d]) * PROD_BITS'(r_kern[i_cmd.tap_j]);
    assign term    = use_tap ? ACC_BITS'(prod) : '0;
    assign n_acc   = r_acc + term;

    // tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= CFG_BITS'(1);
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_data;
        end
    end

    // kernel tap store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_kern[k] <= '0;
            end
        end else if (i_cmd.tap_wr && (32'(i_tap_index) < MAX_TAPS)) begin
            r_kern[IDX_BITS'(i_tap_index)] <= i_item_value;
        end
    end

    // sample window and sample count, entry 0 is the newest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.win_clr) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_win[k] <= '0;
            end
            r_seen <= '0;
        end else if (i_cmd.smp_push) begin
            for (int k = MAX_TAPS - 1; k > 0; k--) begin
                r_win[k] <= r_win[k-1];
            end
            r_win[0] <= i_item_value;
            r_seen   <= o_sts.seen_next;
        end
    end

    // accumulator and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.mac_en) begin
            r_acc <= n_acc;
        end
        if (i_cmd.out_load) begin
            r_out      <= n_acc;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_filtered_value = r_out;
    assign o_last_output    = r_out_last;

endmodule

FILE: rtl/cfc_ctrl.sv
// controller of the centered fir correlator: accepts transactions,
// steps the tap counter and the output lag, hands results out
// depends on cfc_pkg
module cfc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_command,
    input  logic             i_last_sample,
    output logic             o_valid,
    input  logic             i_stall,
    input  cfc_pkg::t_dp_sts i_sts,
    output cfc_pkg::t_dp_cmd o_cmd
);
    import cfc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;

    logic [1:0]          r_state, n_state;
    logic [IDX_BITS-1:0] r_lag, n_lag;
    logic [IDX_BITS-1:0] r_j, n_j;
    logic                r_last_mode, n_last_mode;
    logic                r_ovalid, n_ovalid;

    logic                in_acc;
    logic                out_acc;
    logic                out_free;
    logic [CNT_BITS-1:0] first;
    logic                last_tap;

    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_acc  = r_ovalid && !i_stall;
    assign out_free = !r_ovalid || out_acc;
    assign first    = i_sts.seen_next - CNT_BITS'(1);
    assign last_tap = (CNT_BITS'(r_j) == i_sts.taps - CNT_BITS'(1));

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_lag       = r_lag;
        n_j         = r_j;
        n_last_mode = r_last_mode;
        n_ovalid    = r_ovalid && !out_acc;
        o_cmd       = '0;
        o_cmd.lag   = r_lag;
        o_cmd.tap_j = r_j;
        o_cmd.out_last = r_last_mode && (r_lag == '0);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_TAP) begin
                        o_cmd.tap_wr = 1'b1;
                    end else begin
                        o_cmd.smp_push = 1'b1;
                        n_last_mode    = i_last_sample;
                        n_j            = '0;
                        o_cmd.acc_clr  = 1'b1;
                        if (i_last_sample) begin
                            n_state = S_MAC;
                            if (first > CNT_BITS'(i_sts.look)) begin
                                n_lag = i_sts.look;
                            end else begin
                                n_lag = IDX_BITS'(first);
                            end
                        end else if (i_sts.seen_next > CNT_BITS'(i_sts.look)) begin
                            n_state = S_MAC;
                            n_lag   = i_sts.look;
                        end
                    end
                end
            end
            S_MAC: begin
                // the final tap waits while the result register is still taken
                if (!last_tap || out_free) begin
                    o_cmd.mac_en = 1'b1;
                    if (last_tap) begin
                        o_cmd.out_load = 1'b1;
                        n_ovalid       = 1'b1;
                        if (r_last_mode && (r_lag != '0)) begin
                            n_lag         = r_lag - IDX_BITS'(1);
                            n_j           = '0;
                            o_cmd.acc_clr = 1'b1;
                        end else begin
                            o_cmd.win_clr = r_last_mode;
                            n_state       = S_IDLE;
                        end
                    end else begin
                        n_j = r_j + IDX_BITS'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lag       <= '0;
            r_j         <= '0;
            r_last_mode <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lag       <= n_lag;
            r_j         <= n_j;
            r_last_mode <= n_last_mode;
            r_ovalid    <= n_ovalid;
        end
    end

endmodule

FILE: rtl/cfc_checker.sv
// port-level checks for the centered fir correlator
// bound to centered_fir_correlator; depends on cfc_pkg
module cfc_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic                                   i_command,
    input logic                                   i_last_sample,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic signed [cfc_pkg::ACC_BITS-1:0]    o_filtered_value
);
    import cfc_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_filtered_value)))
        else $error("result changed while stalled");

    // a new result only follows a busy cycle
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a computation");

    // reset leaves the block idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not idle after reset");

    // a tap load gives no new result and keeps the input open
    a_tap_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_command == CMD_TAP)) |=> (!o_stall && !$rose(o_valid)))
        else $error("tap load produced activity");

    // a last sample always starts a flush
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_command == CMD_SAMPLE) && i_last_sample)
        |=> o_stall)
        else $error("last sample did not start flush");

endmodule

bind centered_fir_correlator cfc_checker u_cfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_command        (i_command),
    .i_last_sample    (i_last_sample),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_filtered_value (o_filtered_value)
);

FILE: test/tb_centered_fir_correlator.sv
// self-checking testbench for centered_fir_correlator: a behavioral predictor
// of the correlator checks every output transaction; depends on cfc_pkg and the rtl
// directed tests first, then random signals under random valid and stall gaps
module tb_centered_fir_correlator;
    import cfc_pkg::*;

    localparam int RAND_ITEMS    = 125;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 64;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int MAX_REPORTS   = 20;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] value;
        logic                       last;
    } fir_out_t;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [CFG_BITS-1:0]           i_cfg_data;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_command;
    logic [TIDX_BITS-1:0]          i_tap_index;
    logic signed [SAMPLE_BITS-1:0] i_item_value;
    logic                          i_last_sample;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [ACC_BITS-1:0]    o_filtered_value;
    logic                          o_last_output;

    // predictor state
    logic signed [SAMPLE_BITS-1:0] kernel_m [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] window_m [MAX_TAPS];
    int                            seen_m;
    logic [CFG_BITS-1:0]           tap_count_m;
    fir_out_t                      expected_q[$];

    // run bookkeeping
    int n_errors;
    int n_items;
    int n_results;
    int n_signals;
    int n_cfg;
    int quiet_cycles;
    bit burst_mode;
    bit hold_req;

    centered_fir_correlator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_tap_index      (i_tap_index),
        .i_item_value     (i_item_value),
        .i_last_sample    (i_last_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_value (o_filtered_value),
        .o_last_output    (o_last_output)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // taps in use, with out-of-range counts clamped
    function automatic int taps_in_use();
        if (tap_count_m == 0) begin
            return 1;
        end
        if (tap_count_m > MAX_TAPS) begin
            return MAX_TAPS;
        end
        return int'(tap_count_m);
    endfunction

    // correlation sum for the output lag positions behind the newest sample
    function automatic logic signed [ACC_BITS-1:0] lag_sum(input int lag, input int nt);
        logic signed [ACC_BITS-1:0] acc;
        int                         center;
        int                         d;
        int                         j;
        acc    = '0;
        center = nt / 2;
        for (j = 0; j < nt; j++) begin
            d = lag + center - j;
            if (d >= 0 && d < MAX_TAPS) begin
                acc = acc + ACC_BITS'(window_m[d]) * ACC_BITS'(kernel_m[j]);
            end
        end
        return acc;
    endfunction

    function automatic void push_result(input logic signed [ACC_BITS-1:0] v, input logic lst);
        fir_out_t r;
        r.value = v;
        r.last  = lst;
        expected_q.push_back(r);
    endfunction

    // advance the predictor by one accepted input transaction
    function automatic void predict_item(input logic cmd, input logic [TIDX_BITS-1:0] idx,
                                         input logic signed [SAMPLE_BITS-1:0] val,
                                         input logic lst);
        int nt;
        int look;
        int lag;
        int k;
        if (cmd == CMD_TAP) begin
            kernel_m[idx] = val;
        end else begin
            for (k = MAX_TAPS - 1; k > 0; k--) begin
                window_m[k] = window_m[k-1];
            end
            window_m[0] = val;
            if (seen_m < MAX_TAPS) begin
                seen_m++;
            end
            nt   = taps_in_use();
            look = nt - 1 - nt / 2;
            if (!lst) begin
                if (seen_m > look) begin
                    push_result(lag_sum(look, nt), 1'b0);
                end
            end else begin
                // flush the pending outputs, oldest first, then clear the window
                lag = (seen_m - 1 > look) ? look : seen_m - 1;
                while (lag >= 0) begin
                    push_result(lag_sum(lag, nt), lag == 0);
                    lag--;
                end
                for (k = 0; k < MAX_TAPS; k++) begin
                    window_m[k] = '0;
                end
                seen_m = 0;
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
        n_errors++;
    endtask

    // predictor update and result check on every accepted transaction
    always @(posedge i_clk) begin
        fir_out_t want;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (i_valid && !o_stall) begin
                predict_item(i_command, i_tap_index, i_item_value, i_last_sample);
                n_items++;
                if (i_command == CMD_SAMPLE && i_last_sample) begin
                    n_signals++;
                end
            end
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d last %0b",
                                              o_filtered_value, o_last_output));
                end else begin
                    want = expected_q.pop_front();
                    if (o_filtered_value !== want.value) begin
                        report_mismatch($sformatf("result %0d: value %0d, expected %0d",
                                                  n_results, o_filtered_value, want.value));
                    end
                    if (o_last_output !== want.last) begin
                        report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                                  n_results, o_last_output, want.last));
                    end
                end
            end
        end
    end

    // receiver: random stall before each result, plus one long hold on request
    initial begin
        int n;
        i_stall <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            n = burst_mode ? 0 : $urandom_range(0, 7);
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid && !hold_req) @(posedge i_clk);
        end
    end

    // watchdog on cycles without any accepted transaction
    initial begin
        quiet_cycles = 0;
        @(posedge i_clk);
        while (quiet_cycles < WATCHDOG_MAX) @(posedge i_clk);
        $display("timeout: no transaction for %0d cycles", WATCHDOG_MAX);
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one input transaction after a random gap and wait for it to be taken
    task automatic send_item(input logic cmd, input logic [TIDX_BITS-1:0] idx,
                             input logic signed [SAMPLE_BITS-1:0] val, input logic lst);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_tap_index   <= idx;
        i_item_value  <= val;
        i_last_sample <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic load_tap(input logic [TIDX_BITS-1:0] idx,
                            input logic signed [SAMPLE_BITS-1:0] val);
        send_item(CMD_TAP, idx, val, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] val, input logic lst);
        send_item(CMD_SAMPLE, TIDX_BITS'($urandom_range(0, 15)), val, lst);
    endtask

    // sender pause until every expected result is out and the block settles
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tap_count(input logic [CFG_BITS-1:0] cnt);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cnt;
        @(posedge i_clk);
        tap_count_m = cnt;
        i_cfg_we <= 1'b0;
        n_cfg++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return -16'sd1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_tap_count();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'd31;
            2:       return CFG_BITS'($urandom_range(17, 30));
            3:       return 5'd16;
            default: return CFG_BITS'($urandom_range(1, 16));
        endcase
    endfunction

    // reset values: one tap, zero kernel
    task automatic test_reset_state();
        send_sample(16'sd1234, 1'b0);
        send_sample(-16'sd77, 1'b1);
    endtask

    // extreme products, sum wrap, top tap index stored but unused
    task automatic test_wrap_extremes();
        int k;
        write_tap_count(5'd4);
        for (k = 0; k < 4; k++) begin
            load_tap(TIDX_BITS'(k), 16'sh8000);
        end
        send_item(CMD_TAP, 4'd15, 16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b1);
    endtask

    // tap counts of zero, maximum and above maximum
    task automatic test_count_limits();
        write_tap_count(5'd0);
        send_sample(16'sh7fff, 1'b1);
        write_tap_count(5'd16);
        send_sample(-16'sd300, 1'b1);
        write_tap_count(5'd31);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd5, 1'b1);
    endtask

    // tap count and a tap changed inside a signal
    task automatic test_midsignal_change();
        write_tap_count(5'd3);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd2000, 1'b0);
        write_tap_count(5'd6);
        load_tap(4'd5, -16'sd9);
        send_sample(16'sd3000, 1'b0);
        send_sample(16'sd4000, 1'b1);
    endtask

    // receiver holds off while a burst of samples fills the block
    task automatic test_output_hold();
        int k;
        write_tap_count(5'd8);
        burst_mode = 1'b1;
        hold_req   = 1'b1;
        for (k = 0; k < 14; k++) begin
            send_sample(pick_value(), k == 13);
        end
        burst_mode = 1'b0;
        wait_idle();
    endtask

    // random signals with tap reloads, count changes and stray items
    task automatic test_random_signals();
        int sent;
        int len;
        int k;
        int ntap;
        bit flag_last;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                write_tap_count(pick_tap_count());
            end
            ntap = $urandom_range(0, 4);
            for (k = 0; k < ntap; k++) begin
                load_tap(TIDX_BITS'($urandom_range(0, 15)), pick_value());
                sent++;
            end
            len       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 20);
            flag_last = ($urandom_range(0, 7) != 0);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    load_tap(TIDX_BITS'($urandom_range(0, 15)), pick_value());
                    sent++;
                end
                send_sample(pick_value(), flag_last && (k == len - 1));
                sent++;
            end
        end
        burst_mode = 1'b0;
    endtask

    // main sequence
    initial begin
        int k;
        n_errors      = 0;
        n_items       = 0;
        n_results     = 0;
        n_signals     = 0;
        n_cfg         = 0;
        burst_mode    = 1'b0;
        hold_req      = 1'b0;
        seen_m        = 0;
        tap_count_m   = 5'd1;
        for (k = 0; k < MAX_TAPS; k++) begin
            kernel_m[k] = '0;
            window_m[k] = '0;
        end
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_command     <= CMD_TAP;
        i_tap_index   <= '0;
        i_item_value  <= '0;
        i_last_sample <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_wrap_extremes();
        test_count_limits();
        test_midsignal_change();
        test_output_hold();
        test_random_signals();
        wait_idle();

        if (expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));
        end
        $display("run covered %0d input and %0d output transactions, %0d signals,",
                 n_items, n_results, n_signals);
        $display("%0d tap_count writes, long receiver hold and sender pauses", n_cfg);
        $display("mismatches found: %0d", n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: centered_fir_correlator.f
rtl/cfc_pkg.sv
rtl/cfc_dp.sv
rtl/cfc_ctrl.sv
rtl/centered_fir_correlator.sv
rtl/cfc_checker.sv
test/tb_centered_fir_correlator.sv
